@@ design/ata_pkg.sv @@
// package: payload types, arctangent table and fixed-point constants for the tilt block
`timescale 1ns / 1ps
package ata_pkg;

  localparam int DATA_W    = 48;
  localparam int ZW        = 27;
  localparam int FRAC_BITS = 24;
  localparam int TABLE_LEN = 32;
  localparam logic signed [26:0] GAIN_Q24  = 27'sd27628053;
  localparam logic signed [16:0] SCALE_NUM = 17'sd57295;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] angle_x;
    logic signed [7:0] angle_y;
    logic signed [7:0] angle_z;
  } out_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [ZW-1:0]     z;
    logic                     zero;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int unsigned i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        0:  v = 27'sd13176795;
        1:  v = 27'sd7778716;
        2:  v = 27'sd4110060;
        3:  v = 27'sd2086331;
        4:  v = 27'sd1047214;
        5:  v = 27'sd524117;
        6:  v = 27'sd262123;
        7:  v = 27'sd131069;
        default: v = (i < 25) ? (27'sd1 <<< (24 - i)) : 27'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

@@ design/ata_cell.sv @@
// one vectoring cordic stage with its register
`timescale 1ns / 1ps
module ata_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  ata_pkg::cordic_t d_in,
  output logic            vld_out,
  output ata_pkg::cordic_t d_out
);
  localparam int SH = (STAGE < 63) ? STAGE : 63;
  localparam logic signed [ata_pkg::ZW-1:0] ANG = ata_pkg::atan_q24(STAGE);

  ata_pkg::cordic_t d_nxt;
  ata_pkg::cordic_t d_r;
  logic vld_r;

  always_comb begin
    d_nxt = d_in;
    if (!d_in.y[ata_pkg::DATA_W-1]) begin
      d_nxt.x = d_in.x + (d_in.y >>> SH);
      d_nxt.y = d_in.y - (d_in.x >>> SH);
      d_nxt.z = d_in.z + ANG;
    end else begin
      d_nxt.x = d_in.x - (d_in.y >>> SH);
      d_nxt.y = d_in.y + (d_in.x >>> SH);
      d_nxt.z = d_in.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;
endmodule

@@ design/ata_axis.sv @@
// one axis angle: magnitude chain, gain multiply, angle chain, degree scaling
`timescale 1ns / 1ps
module ata_axis #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  input  logic signed [15:0] c,
  output logic               vld_out,
  output logic signed [7:0]  angle
);
  localparam int DW = ata_pkg::DATA_W;

  ata_pkg::cordic_t m_d [CORDIC_STAGES+1];
  logic             m_v [CORDIC_STAGES+1];
  logic signed [15:0] a_pipe_r [CORDIC_STAGES];

  ata_pkg::cordic_t g_d_r;
  logic             g_v_r;
  ata_pkg::cordic_t p_d [CORDIC_STAGES+1];
  logic             p_v [CORDIC_STAGES+1];

  logic signed [16:0] bb;
  logic signed [42:0] gprod;
  logic signed [43:0] prod_r;
  logic               s_v_r;
  logic               s_zero_r;
  logic signed [31:0] deg_full;
  logic signed [7:0]  angle_r;
  logic               vld_r;

  assign bb = b[15] ? -{b[15], b} : {b[15], b};

  always_comb begin
    m_d[0].x    = DW'(bb) <<< ata_pkg::FRAC_BITS;
    m_d[0].y    = DW'(c) <<< ata_pkg::FRAC_BITS;
    m_d[0].z    = '0;
    m_d[0].zero = (a == 16'sd0) && (b == 16'sd0) && (c == 16'sd0);
    m_v[0]      = vld_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pipe_r[0] <= a;
      for (int k = 1; k < CORDIC_STAGES; k++) a_pipe_r[k] <= a_pipe_r[k-1];
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_mag
    ata_cell #(.STAGE(i)) u_cell (
      .clk, .rst_n, .en, .vld_in(m_v[i]), .d_in(m_d[i]),
      .vld_out(m_v[i+1]), .d_out(m_d[i+1])
    );
  end

  assign gprod = 43'(a_pipe_r[CORDIC_STAGES-1]) * 43'(ata_pkg::GAIN_Q24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= m_v[CORDIC_STAGES];
    end
    if (en) begin
      g_d_r.x    <= m_d[CORDIC_STAGES].x;
      g_d_r.y    <= -DW'(gprod);
      g_d_r.z    <= '0;
      g_d_r.zero <= m_d[CORDIC_STAGES].zero;
    end
  end

  assign p_d[0] = g_d_r;
  assign p_v[0] = g_v_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_ang
    ata_cell #(.STAGE(i)) u_cell (
      .clk, .rst_n, .en, .vld_in(p_v[i]), .d_in(p_d[i]),
      .vld_out(p_v[i+1]), .d_out(p_d[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
      vld_r <= 1'b0;
    end else if (en) begin
      s_v_r <= p_v[CORDIC_STAGES];
      vld_r <= s_v_r;
    end
    if (en) begin
      prod_r   <= 44'(p_d[CORDIC_STAGES].z) * 44'(ata_pkg::SCALE_NUM);
      s_zero_r <= p_d[CORDIC_STAGES].zero;
      angle_r  <= s_zero_r ? 8'sd0 :
                  (deg_full > 32'sd89)  ? 8'sd89 :
                  (deg_full < -32'sd89) ? -8'sd89 : deg_full[7:0];
    end
  end

  // divide by 1000 * 2^24, truncated toward zero
  logic [43:0] pmag;
  logic [19:0] qhi;
  logic [40:0] qprod;
  logic [31:0] q;
  assign pmag     = prod_r[43] ? 44'(-prod_r) : 44'(prod_r);
  assign qhi      = pmag[43:24];
  assign qprod    = 41'(qhi) * 41'd1073742;
  assign q        = {21'd0, qprod[40:30]};
  assign deg_full = prod_r[43] ? -$signed(q) : $signed(q);

  assign vld_out = vld_r;
  assign angle   = angle_r;
endmodule

@@ design/accel_tilt_angles_top.sv @@
// top level: three-axis tilt angles from one accelerometer sample
`timescale 1ns / 1ps
// usage:
//   in_valid / in_stall / in_data carry one sample (x, y, z raw counts) per beat
//   out_valid / out_stall / out_data carry one beat of three angles in degrees
//   each axis runs through a chain of CORDIC_STAGES magnitude cells, one gain
//   multiply register, CORDIC_STAGES angle cells and two scaling registers
//   throughput: one sample per cycle while out_stall is low
//   the whole chain is held by out_stall when the output beat is waiting,
//   so in_stall follows out_stall whenever the output register is full
//   a sample with all axes zero yields zero angles
//   reset (rst_n low, synchronous) empties every stage; no beats are in flight
//   after reset and out_valid is low
module accel_tilt_angles_top #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ata_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ata_pkg::out_beat_t out_data
);
  logic en;
  logic v_x, v_y, v_z;
  logic signed [7:0] ang_x, ang_y, ang_z;

  assign en       = !(v_x && out_stall);
  assign in_stall = !en;

  ata_axis #(.CORDIC_STAGES(CORDIC_STAGES)) u_x (
    .clk, .rst_n, .en, .vld_in(in_valid),
    .a(in_data.accel_x), .b(in_data.accel_y), .c(in_data.accel_z),
    .vld_out(v_x), .angle(ang_x)
  );
  ata_axis #(.CORDIC_STAGES(CORDIC_STAGES)) u_y (
    .clk, .rst_n, .en, .vld_in(in_valid),
    .a(in_data.accel_y), .b(in_data.accel_x), .c(in_data.accel_z),
    .vld_out(v_y), .angle(ang_y)
  );
  ata_axis #(.CORDIC_STAGES(CORDIC_STAGES)) u_z (
    .clk, .rst_n, .en, .vld_in(in_valid),
    .a(in_data.accel_z), .b(in_data.accel_x), .c(in_data.accel_y),
    .vld_out(v_z), .angle(ang_z)
  );

  assign out_valid        = v_x;
  assign out_data.angle_x = ang_x;
  assign out_data.angle_y = ang_y;
  assign out_data.angle_z = ang_z;

`ifndef NO_ASSERTIONS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (v_x == v_y) && (v_x == v_z)) else $error("axis lanes out of step");
  a_range_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ang_x <= 8'sd89 && ang_x >= -8'sd89)) else $error("angle_x range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif
endmodule
